[rtl/sha384_pkg.sv]
// ----------------------------------------------------------------------------
// sha384_pkg
// Shared types, constants and the rotate function of the SHA-384 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha384_pkg;

   localparam int ROUNDS = 80;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_of_digest;
   } rsp_type;

   // word source for a schedule write
   typedef enum logic [2:0] {
      SRC_DATA,
      SRC_ZERO,
      SRC_MARK,
      SRC_LEN_HI,
      SRC_LEN_LO
   } src_type;

   typedef struct packed {
      logic       load_word;    // write one word into the window
      src_type    src;
      logic       start_block;  // copy chaining words into working vars
      logic       do_round;     // one compression round
      logic       finish_block; // add working vars into chain
      logic       reset_chain;  // return to initial values
      logic [2:0] out_index;
   } cmd_type;

   typedef struct packed {
      logic [3:0] words_in_block;
      logic [6:0] round_count;
   } sts_type;

   localparam logic [63:0] INIT_CHAIN [8] = '{
      64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
      64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
      64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
   };

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
      64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
      64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
      64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
      64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
      64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
      64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
      64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
      64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
      64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
      64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
      64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
      64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
      64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
      64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
      64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
      64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
      64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
      64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
      64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
   };

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

endpackage
`default_nettype wire

[rtl/sha384_datapath.sv]
// ----------------------------------------------------------------------------
// sha384_datapath
// Schedule window, working variables, chaining words, length and round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module sha384_datapath
   import sha384_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire req_type     req_data,
   input  wire logic        req_take,   // input transaction accepted
   output sts_type          sts,
   output logic [63:0]      chain_word
);

   logic [63:0] window_ff [16];
   logic [63:0] vars_ff [8];
   logic [63:0] chain_ff [8];
   logic [63:0] chain_in [8];
   logic [3:0]  words_ff, words_in;
   logic [6:0]  round_ff, round_in;
   logic [63:0] bytes_ff, bytes_in;
   logic [63:0] pad_word, load_value, w_new, wi, t1, t2, e, a;
   logic [3:0]  n_eff;
   logic [3:0]  r_idx;
   logic [5:0]  shift_amt;
   logic [63:0] keep;

   assign sts.words_in_block = words_ff;
   assign sts.round_count    = round_ff;
   assign chain_word = chain_ff[cmd.out_index];

   // padded data word for a last transaction
   always_comb begin
      n_eff = (!req_data.last_word || req_data.byte_count > 4'd8) ? 4'd8
              : req_data.byte_count;
      shift_amt = 6'(7 - n_eff[2:0]) << 3;
      keep = (n_eff == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {n_eff[3:0], 3'b000});
      if (n_eff == 4'd8)
         pad_word = req_data.data_word;
      else
         pad_word = (req_data.data_word & keep) | (64'h80 << shift_amt);
   end

   always_comb begin
      unique case (cmd.src)
         SRC_DATA:   load_value = pad_word;
         SRC_ZERO:   load_value = 64'd0;
         SRC_MARK:   load_value = {8'h80, 56'd0};
         SRC_LEN_HI: load_value = {61'd0, bytes_ff[63:61]};
         SRC_LEN_LO: load_value = {bytes_ff[60:0], 3'b000};
         default:    load_value = 64'd0;
      endcase
   end

   // round logic
   always_comb begin
      r_idx = round_ff[3:0];
      w_new = window_ff[r_idx]
            + (rotr(window_ff[4'(r_idx - 4'd2)], 19) ^ rotr(window_ff[4'(r_idx - 4'd2)], 61)
               ^ (window_ff[4'(r_idx - 4'd2)] >> 6))
            + window_ff[4'(r_idx - 4'd7)]
            + (rotr(window_ff[4'(r_idx - 4'd15)], 1) ^ rotr(window_ff[4'(r_idx - 4'd15)], 8)
               ^ (window_ff[4'(r_idx - 4'd15)] >> 7));
      wi = (round_ff >= 7'd16) ? w_new : window_ff[r_idx];
      e  = vars_ff[4];
      a  = vars_ff[0];
      t1 = vars_ff[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
         + ((e & vars_ff[5]) ^ (~e & vars_ff[6])) + ROUND_K[round_ff] + wi;
      t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
         + ((a & vars_ff[1]) ^ (a & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]));
   end

   always_comb begin
      words_in = words_ff;
      round_in = round_ff;
      bytes_in = bytes_ff;
      for (int i = 0; i < 8; i++) begin
         chain_in[i] = chain_ff[i];
         if (cmd.finish_block)
            chain_in[i] = chain_ff[i] + vars_ff[i];
         if (cmd.reset_chain)
            chain_in[i] = INIT_CHAIN[i];
      end
      if (cmd.load_word)
         words_in = words_ff + 4'd1;
      if (req_take)
         bytes_in = bytes_ff + 64'(n_eff);
      if (cmd.do_round)
         round_in = (round_ff == 7'(ROUNDS - 1)) ? 7'd0 : round_ff + 7'd1;
      if (cmd.reset_chain) begin
         words_in = 4'd0;
         bytes_in = 64'd0;
         round_in = 7'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= 4'd0;
         round_ff <= 7'd0;
         bytes_ff <= 64'd0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= INIT_CHAIN[i];
      end else begin
         words_ff <= words_in;
         round_ff <= round_in;
         bytes_ff <= bytes_in;
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word)
         window_ff[words_ff] <= load_value;
      if (cmd.do_round && round_ff >= 7'd16)
         window_ff[r_idx] <= w_new;
      if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) vars_ff[i] <= chain_ff[i];
      end else if (cmd.do_round) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

endmodule
`default_nettype wire

[rtl/sha384_control.sv]
// ----------------------------------------------------------------------------
// sha384_control
// Sequencer: word intake, padding, round count and digest read-out.
// ----------------------------------------------------------------------------
`default_nettype none
module sha384_control
   import sha384_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [2:0]   out_index
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_ROUND, ST_FINISH, ST_PAD, ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic        pad_ff, pad_in;        // padding pending after this block
   logic        extra_ff, extra_in;    // 0x80 word still owed
   logic        hi_ff, hi_in;          // upper length word written
   logic [2:0]  idx_ff, idx_in;
   logic        full_last;
   // set once the length words are in: the block holding them ends the message
   logic        pad_done_ff, pad_done_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign out_index = idx_ff;
   assign full_last = req_data.last_word &&
                      (req_data.byte_count == 4'd8 || req_data.byte_count > 4'd8);

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      extra_in = extra_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.src  = SRC_DATA;
      cmd.out_index = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_word = 1'b1;
               pad_in   = req_data.last_word;
               extra_in = full_last;
               if (sts.words_in_block == 4'd15)
                  state_in = ST_START;
               else if (req_data.last_word)
                  state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.load_word = 1'b1;
            if (extra_ff) begin
               cmd.src  = SRC_MARK;
               extra_in = 1'b0;
            end else if (sts.words_in_block == 4'd14) begin
               cmd.src = SRC_LEN_HI;
               hi_in   = 1'b1;
            end else if (sts.words_in_block == 4'd15 && hi_ff) begin
               cmd.src = SRC_LEN_LO;
               pad_in  = 1'b0;
               hi_in   = 1'b0;
            end else begin
               cmd.src = SRC_ZERO;
            end
            if (sts.words_in_block == 4'd15)
               state_in = ST_START;
         end
         ST_START: begin
            cmd.start_block = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (sts.round_count == 7'(ROUNDS - 1))
               state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish_block = 1'b1;
            if (pad_ff || extra_ff)
               state_in = ST_PAD;
            else if (pad_done_ff)
               state_in = ST_OUT;
            else
               state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd5) begin
                  idx_in = 3'd0;
                  cmd.reset_chain = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pad_done_in = pad_done_ff;
      if (state_ff == ST_PAD && sts.words_in_block == 4'd15 && hi_ff)
         pad_done_in = 1'b1;
      if (state_ff == ST_OUT)
         pad_done_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pad_ff      <= 1'b0;
         extra_ff    <= 1'b0;
         hi_ff       <= 1'b0;
         idx_ff      <= 3'd0;
         pad_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pad_ff      <= pad_in;
         extra_ff    <= extra_in;
         hi_ff       <= hi_in;
         idx_ff      <= idx_in;
         pad_done_ff <= pad_done_in;
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input and output open together");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= 3'd5) else $error("digest index out of range");
   a_round_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_START |=> sts.round_count == 7'd0) else $error("round count not clear");
   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && idx_ff == 3'd5 |=> req_ready) else $error("no return to idle");

endmodule
`default_nettype wire

[rtl/sha384_hash_engine_unit.sv]
// ----------------------------------------------------------------------------
// sha384_hash_engine_unit
// SHA-384 digest of a byte message delivered as big-endian 64-bit words.
// ----------------------------------------------------------------------------
// Input: req_valid/req_ready carry one message word per transaction with
// its byte count and last flag. Output: rsp_valid/rsp_ready deliver six
// digest words, index 0 first, last_of_digest on index 5.
// A non-final word is accepted in the idle state; the sixteenth of a block
// then runs the compression: a start step, 80 rounds (one round per cycle
// through the single round unit) and an add step, and no new word is taken
// until it is through. A last word is followed by padding words, one per
// cycle up to the end of the block, one or two compressions, then the six
// digest words, one per cycle while the receiver is ready.
// The block takes no input while a digest is being read; a stalled receiver
// holds the current digest word until it is taken.
// Reset loads the SHA-384 initial chaining values and clears the counters.
// ----------------------------------------------------------------------------
`default_nettype none
module sha384_hash_engine_unit
   import sha384_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type     cmd;
   sts_type     sts;
   logic [63:0] chain_word;
   logic [2:0]  out_index;

   sha384_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_data, .sts, .cmd,
      .rsp_valid, .rsp_ready, .out_index
   );

   sha384_datapath u_datapath (
      .clock, .reset, .cmd, .req_data,
      .req_take(req_valid && req_ready), .sts, .chain_word
   );

   assign rsp_data.digest_word    = chain_word;
   assign rsp_data.word_index     = out_index;
   assign rsp_data.last_of_digest = (out_index == 3'd5);

endmodule
`default_nettype wire
